### design/headset_jack_type_detector_macros.svh
// assertion helpers for the detector rtl
`ifndef HEADSET_JACK_TYPE_DETECTOR_MACROS_SVH
`define HEADSET_JACK_TYPE_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle
`define HJTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define HJTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hjtd_pkg.sv
package hjtd_pkg;

	localparam int ZONE_REGS = 4;
	localparam int ZIDX_W    = $clog2(ZONE_REGS);
	localparam int ZW_W      = 39;
	localparam int ADC_W     = 12;
	localparam int TYPE_W    = 3;
	localparam int MS_W      = 10;
	localparam int TMR_W     = 16;

	// zone word layout
	localparam int ZF_HIGH_LSB = 0;
	localparam int ZF_CHK_LSB  = 12;
	localparam int ZF_DLY_LSB  = 20;
	localparam int ZF_TYP_LSB  = 36;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_SETTLE   = 2'd2;
	localparam logic [1:0] PH_CLASSIFY = 2'd3;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_FORCE = 1'b1;

	localparam logic [TYPE_W-1:0] TYPE_NONE      = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_FOUR_POLE = 3'd1;

	localparam logic [2:0] REG_DETECT_DB = 3'd0;
	localparam logic [2:0] REG_SETTLE    = 3'd1;
	localparam logic [2:0] REG_KEY_DB    = 3'd2;
	localparam logic [2:0] REG_ZONES     = 3'd3;
	localparam logic [2:0] REG_ZONE0     = 3'd4;
	localparam logic [2:0] REG_ZONE1     = 3'd5;
	localparam logic [2:0] REG_ZONE2     = 3'd6;
	localparam logic [2:0] REG_ZONE3     = 3'd7;

	localparam logic [MS_W-1:0] DETECT_DB_RST = 10'd100;
	localparam logic [MS_W-1:0] SETTLE_RST    = 10'd200;
	localparam logic [MS_W-1:0] KEY_DB_RST    = 10'd120;
	localparam logic [2:0]      ZONES_RST     = 3'd4;

	typedef struct packed {
		logic              hit;
		logic [ZIDX_W-1:0] idx;
		logic [7:0]        chk;
		logic [15:0]       dly;
		logic [TYPE_W-1:0] typ;
	} zone_sel_t;

endpackage

### design/hjtd_zone_match.sv
module hjtd_zone_match import hjtd_pkg::*; (
	input  logic [ZONE_REGS-1:0][ZW_W-1:0] zone_word,
	input  logic [2:0]                     limit,
	input  logic [ADC_W-1:0]               adc,
	output zone_sel_t                      sel
);

	logic found;

	// first zone below limit, in ascending order, whose upper bound covers the sample
	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int i = 0; i < ZONE_REGS; i++) begin
			if (!found && (3'(i) < limit) &&
			    (adc <= zone_word[i][ZF_HIGH_LSB +: ADC_W])) begin
				found   = 1'b1;
				sel.hit = 1'b1;
				sel.idx = ZIDX_W'(i);
				sel.chk = zone_word[i][ZF_CHK_LSB +: 8];
				sel.dly = zone_word[i][ZF_DLY_LSB +: 16];
				sel.typ = zone_word[i][ZF_TYP_LSB +: TYPE_W];
			end
		end
	end

endmodule

### design/headset_jack_type_detector.sv
// pipeline: an accepted request is held in the input stage, then its result is registered
// throughput: one request per cycle unless out_stall holds the result stage; the state update
// of a tick is combinational between the input stage and the result register, so back-to-back requests stream
// reset: arst_n clears all detection and key state, empties both stages and loads
// the default timing registers; zone words reset to zero
`include "headset_jack_type_detector_macros.svh"

module headset_jack_type_detector import hjtd_pkg::*; #(
	parameter int MAX_ZONES = 4
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic              det_level,
	input  logic              send_level,
	input  logic [ADC_W-1:0]  adc_sample,
	input  logic              in_call,
	input  logic [TYPE_W-1:0] forced_type,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [TYPE_W-1:0] plug_type,
	output logic              type_changed,
	output logic              micbias_on,
	output logic              key_pressed,
	output logic              key_changed,
	output logic              detecting,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	localparam int ZONES_IMPL = (MAX_ZONES < ZONE_REGS) ? MAX_ZONES : ZONE_REGS;

	typedef struct packed {
		logic [TYPE_W-1:0] typ;
		logic              key_en;
		logic              key_deb;
		logic              key_st;
		logic              bias;
	} kst_t;

	function automatic kst_t set_type(input kst_t s, input logic [TYPE_W-1:0] t);
		kst_t r;
		r = s;
		if (t != s.typ) begin
			if (t == TYPE_FOUR_POLE) begin
				r.key_en = 1'b1;
			end else begin
				r.key_en  = 1'b0;
				r.key_deb = 1'b0;
				r.key_st  = 1'b0;
			end
			r.typ  = t;
			r.bias = r.key_en;
		end
		return r;
	endfunction

	// configuration
	logic [MS_W-1:0]                 detect_db_q, settle_q, key_db_q;
	logic [2:0]                      zones_used_q;
	logic [ZONE_REGS-1:0][ZW_W-1:0]  zone_word_q;

	// detector state
	logic [1:0]        phase_q;
	logic [TMR_W-1:0]  phase_timer_q;
	logic [7:0]        zone_hits_q [ZONES_IMPL];
	logic [TYPE_W-1:0] current_type_q;
	logic              key_state_q, key_enabled_q, key_debouncing_q, bias_q;
	logic [MS_W-1:0]   key_timer_q;
	logic              last_det_q, last_send_q;

	// input stage
	logic              valid_s1;
	logic              mode_s1, det_s1, send_s1, call_s1;
	logic [ADC_W-1:0]  adc_s1;
	logic [TYPE_W-1:0] forced_s1;

	// result stage
	logic              valid_s2;
	logic [TYPE_W-1:0] plug_type_s2;
	logic              type_changed_s2, micbias_s2, key_pressed_s2, key_changed_s2;
	logic              detecting_s2;

	logic out_free, adv, in_acc, cfg_wr;

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	always_comb begin
		unique case (paddr[5:3])
			REG_DETECT_DB: prdata = 64'(detect_db_q);
			REG_SETTLE:    prdata = 64'(settle_q);
			REG_KEY_DB:    prdata = 64'(key_db_q);
			REG_ZONES:     prdata = 64'(zones_used_q);
			REG_ZONE0:     prdata = 64'(zone_word_q[0]);
			REG_ZONE1:     prdata = 64'(zone_word_q[1]);
			REG_ZONE2:     prdata = 64'(zone_word_q[2]);
			REG_ZONE3:     prdata = 64'(zone_word_q[3]);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_db_q  <= DETECT_DB_RST;
			settle_q     <= SETTLE_RST;
			key_db_q     <= KEY_DB_RST;
			zones_used_q <= ZONES_RST;
			zone_word_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_DETECT_DB: detect_db_q     <= pwdata[MS_W-1:0];
				REG_SETTLE:    settle_q        <= pwdata[MS_W-1:0];
				REG_KEY_DB:    key_db_q        <= pwdata[MS_W-1:0];
				REG_ZONES:     zones_used_q    <= pwdata[2:0];
				REG_ZONE0:     zone_word_q[0]  <= pwdata[ZW_W-1:0];
				REG_ZONE1:     zone_word_q[1]  <= pwdata[ZW_W-1:0];
				REG_ZONE2:     zone_word_q[2]  <= pwdata[ZW_W-1:0];
				REG_ZONE3:     zone_word_q[3]  <= pwdata[ZW_W-1:0];
				default: ;
			endcase
		end
	end

	// zone search
	logic [2:0] zone_limit;
	zone_sel_t  sel;

	assign zone_limit = (zones_used_q > 3'(ZONES_IMPL)) ? 3'(ZONES_IMPL) : zones_used_q;

	hjtd_zone_match u_match (
		.zone_word (zone_word_q),
		.limit     (zone_limit),
		.adc       (adc_s1),
		.sel       (sel)
	);

	// next state for the request in the input stage
	kst_t              k;
	logic [1:0]        ph_d;
	logic [TMR_W-1:0]  tmr_d, tmr_inc;
	logic [7:0]        hits_d [ZONES_IMPL];
	logic [7:0]        sel_hits, hits_new;
	logic [MS_W-1:0]   ktmr_d;
	logic              ldet_d, lsend_d, det_edge, send_edge;

	always_comb begin
		k.typ     = current_type_q;
		k.key_en  = key_enabled_q;
		k.key_deb = key_debouncing_q;
		k.key_st  = key_state_q;
		k.bias    = bias_q;
		ph_d      = phase_q;
		tmr_d     = phase_timer_q;
		ktmr_d    = key_timer_q;
		ldet_d    = last_det_q;
		lsend_d   = last_send_q;
		det_edge  = det_s1 != last_det_q;
		send_edge = send_s1 != last_send_q;
		tmr_inc   = phase_timer_q + 1'b1;
		sel_hits  = '0;
		for (int i = 0; i < ZONES_IMPL; i++) begin
			hits_d[i] = zone_hits_q[i];
			if (sel.idx == ZIDX_W'(i))
				sel_hits = zone_hits_q[i];
		end
		hits_new = (sel_hits == 8'hff) ? sel_hits : sel_hits + 1'b1;

		if (mode_s1 == MODE_FORCE) begin
			if (forced_s1 == TYPE_FOUR_POLE)
				k.bias = 1'b1;
			k = set_type(k, forced_s1);
		end else begin
			ldet_d  = det_s1;
			lsend_d = send_s1;
			if (det_edge) begin
				ph_d  = PH_DEBOUNCE;
				tmr_d = '0;
				tmr_inc = 16'd1;
				for (int i = 0; i < ZONES_IMPL; i++)
					hits_d[i] = '0;
			end

			if (ph_d != PH_IDLE && !det_s1) begin
				// plug gone: report no device
				k = set_type(k, TYPE_NONE);
				if (!call_s1)
					k.bias = 1'b0;
				ph_d  = PH_IDLE;
				tmr_d = '0;
			end else begin
				unique case (ph_d)
					PH_IDLE: ;
					PH_DEBOUNCE: begin
						if (tmr_inc >= TMR_W'(detect_db_q)) begin
							k.bias = 1'b1;
							ph_d   = (settle_q == '0) ? PH_CLASSIFY : PH_SETTLE;
							tmr_d  = '0;
						end else begin
							tmr_d = tmr_inc;
						end
					end
					PH_SETTLE: begin
						if (tmr_inc >= TMR_W'(settle_q)) begin
							ph_d  = PH_CLASSIFY;
							tmr_d = '0;
						end else begin
							tmr_d = tmr_inc;
						end
					end
					PH_CLASSIFY: begin
						if (phase_timer_q != '0) begin
							tmr_d = phase_timer_q - 1'b1;
						end else if (sel.hit) begin
							for (int i = 0; i < ZONES_IMPL; i++)
								if (sel.idx == ZIDX_W'(i))
									hits_d[i] = hits_new;
							if (hits_new > sel.chk) begin
								k     = set_type(k, sel.typ);
								ph_d  = PH_IDLE;
								tmr_d = '0;
							end else begin
								tmr_d = (sel.dly != '0) ? sel.dly - 1'b1 : '0;
							end
						end
					end
					default: ;
				endcase
			end

			if (send_edge && k.key_en) begin
				if (k.key_st) begin
					k.key_st  = 1'b0;
					k.key_deb = 1'b0;
				end else if (key_db_q != '0) begin
					k.key_deb = 1'b1;
					ktmr_d    = '0;
				end
			end
			if (k.key_deb) begin
				if (!send_s1 || !det_s1 || k.typ != TYPE_FOUR_POLE || !k.key_en) begin
					k.key_deb = 1'b0;
				end else begin
					ktmr_d = ktmr_d + 1'b1;
					if (ktmr_d >= key_db_q) begin
						k.key_deb = 1'b0;
						k.key_st  = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			phase_timer_q    <= '0;
			current_type_q   <= TYPE_NONE;
			key_state_q      <= 1'b0;
			key_enabled_q    <= 1'b0;
			key_debouncing_q <= 1'b0;
			key_timer_q      <= '0;
			bias_q           <= 1'b0;
			last_det_q       <= 1'b0;
			last_send_q      <= 1'b0;
			for (int i = 0; i < ZONES_IMPL; i++)
				zone_hits_q[i] <= '0;
		end else if (adv) begin
			phase_q          <= ph_d;
			phase_timer_q    <= tmr_d;
			current_type_q   <= k.typ;
			key_state_q      <= k.key_st;
			key_enabled_q    <= k.key_en;
			key_debouncing_q <= k.key_deb;
			key_timer_q      <= ktmr_d;
			bias_q           <= k.bias;
			last_det_q       <= ldet_d;
			last_send_q      <= lsend_d;
			for (int i = 0; i < ZONES_IMPL; i++)
				zone_hits_q[i] <= hits_d[i];
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (out_free)
				valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1   <= mode;
			det_s1    <= det_level;
			send_s1   <= send_level;
			adc_s1    <= adc_sample;
			call_s1   <= in_call;
			forced_s1 <= forced_type;
		end
		if (adv) begin
			plug_type_s2    <= k.typ;
			type_changed_s2 <= k.typ != current_type_q;
			micbias_s2      <= k.bias;
			key_pressed_s2  <= k.key_st;
			key_changed_s2  <= k.key_st != key_state_q;
			detecting_s2    <= ph_d != PH_IDLE;
		end
	end

	assign out_valid    = valid_s2;
	assign plug_type    = plug_type_s2;
	assign type_changed = type_changed_s2;
	assign micbias_on   = micbias_s2;
	assign key_pressed  = key_pressed_s2;
	assign key_changed  = key_changed_s2;
	assign detecting    = detecting_s2;

	`HJTD_ASSERT_NOW(a_key_en_tracks_type, 1'b1, key_enabled_q == (current_type_q == TYPE_FOUR_POLE), "key enable out of step with plug type")
	`HJTD_ASSERT_NOW(a_key_needs_enable, key_state_q || key_debouncing_q, key_enabled_q, "key active while key disabled")
	`HJTD_ASSERT_NOW(a_idle_timer_clear, phase_q == PH_IDLE, phase_timer_q == '0, "phase timer running while idle")
	`HJTD_ASSERT_NEXT(a_result_follows, adv, valid_s2, "request advanced but no result shown")

endmodule

### bench/jack_report_checker.sv
`timescale 1ns / 100ps

module jack_report_checker import hjtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              mode,
	input  logic              det_level,
	input  logic              send_level,
	input  logic [ADC_W-1:0]  adc_sample,
	input  logic              in_call,
	input  logic [TYPE_W-1:0] forced_type,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [TYPE_W-1:0] plug_type,
	input  logic              type_changed,
	input  logic              micbias_on,
	input  logic              key_pressed,
	input  logic              key_changed,
	input  logic              detecting,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [TYPE_W-1:0] plug_type;
		logic              type_changed;
		logic              micbias_on;
		logic              key_pressed;
		logic              key_changed;
		logic              detecting;
	} jack_report_t;

	jack_report_t expected_reports[$];

	// register copies
	logic [MS_W-1:0]   det_db_ms;
	logic [MS_W-1:0]   settle_len;
	logic [MS_W-1:0]   key_db_ms;
	logic [2:0]        zones_used;
	logic [ZW_W-1:0]   zone_word [ZONE_REGS];

	// detector state
	logic [1:0]        ph;
	logic [TMR_W-1:0]  ph_tmr;
	logic [7:0]        zone_hits [ZONE_REGS];
	logic [TYPE_W-1:0] cur_type;
	logic              key_st, key_en, key_db, bias, prev_det, prev_send;
	logic [MS_W-1:0]   key_tmr;

	task automatic set_plug_type(input logic [TYPE_W-1:0] t);
		if (t != cur_type) begin
			if (t == TYPE_FOUR_POLE) begin
				key_en = 1'b1;
			end else begin
				key_en = 1'b0;
				key_db = 1'b0;
				key_st = 1'b0;
			end
			cur_type = t;
			bias = key_en;
		end
	endtask

	task automatic report_unplugged(input logic call);
		set_plug_type(TYPE_NONE);
		if (!call)
			bias = 1'b0;
		ph = PH_IDLE;
		ph_tmr = '0;
	endtask

	task automatic sample_zones(input logic [ADC_W-1:0] adc);
		int n;
		int i;
		logic matched;
		logic [ADC_W-1:0] high;
		logic [7:0] chk;
		logic [15:0] dly;
		logic [TYPE_W-1:0] typ;
		n = zones_used;
		if (n > ZONE_REGS)
			n = ZONE_REGS;
		if (ph_tmr > 0) begin
			ph_tmr = ph_tmr - 1'b1;
		end else begin
			matched = 1'b0;
			for (i = 0; i < n; i++) begin
				high = zone_word[i][ZF_HIGH_LSB +: ADC_W];
				chk  = zone_word[i][ZF_CHK_LSB +: 8];
				dly  = zone_word[i][ZF_DLY_LSB +: 16];
				typ  = zone_word[i][ZF_TYP_LSB +: TYPE_W];
				if (!matched && adc <= high) begin
					matched = 1'b1;
					if (zone_hits[i] != 8'hff)
						zone_hits[i] = zone_hits[i] + 1'b1;
					if (zone_hits[i] > chk) begin
						set_plug_type(typ);
						ph = PH_IDLE;
						ph_tmr = '0;
					end else begin
						ph_tmr = (dly > 0) ? dly - 16'd1 : 16'd0;
					end
				end
			end
		end
	endtask

	task automatic predict_tick(output jack_report_t r);
		logic [TYPE_W-1:0] old_type;
		logic old_key, det_edge, send_edge;
		int i;
		old_type = cur_type;
		old_key = key_st;
		if (mode == MODE_FORCE) begin
			if (forced_type == TYPE_FOUR_POLE)
				bias = 1'b1;
			set_plug_type(forced_type);
		end else begin
			det_edge = det_level != prev_det;
			send_edge = send_level != prev_send;
			prev_det = det_level;
			prev_send = send_level;
			if (det_edge) begin
				ph = PH_DEBOUNCE;
				ph_tmr = '0;
				for (i = 0; i < ZONE_REGS; i++)
					zone_hits[i] = '0;
			end
			case (ph)
				PH_DEBOUNCE: begin
					if (!det_level) begin
						report_unplugged(in_call);
					end else begin
						ph_tmr = ph_tmr + 1'b1;
						if (ph_tmr >= det_db_ms) begin
							bias = 1'b1;
							ph = (settle_len == 0) ? PH_CLASSIFY : PH_SETTLE;
							ph_tmr = '0;
						end
					end
				end
				PH_SETTLE: begin
					if (!det_level) begin
						report_unplugged(in_call);
					end else begin
						ph_tmr = ph_tmr + 1'b1;
						if (ph_tmr >= settle_len) begin
							ph = PH_CLASSIFY;
							ph_tmr = '0;
						end
					end
				end
				PH_CLASSIFY: begin
					if (!det_level)
						report_unplugged(in_call);
					else
						sample_zones(adc_sample);
				end
				default: ;
			endcase
			if (send_edge && key_en) begin
				if (key_st) begin
					key_st = 1'b0;
					key_db = 1'b0;
				end else if (key_db_ms != 0) begin
					key_db = 1'b1;
					key_tmr = '0;
				end
			end
			if (key_db) begin
				if (!send_level || !det_level || cur_type != TYPE_FOUR_POLE || !key_en) begin
					key_db = 1'b0;
				end else begin
					key_tmr = key_tmr + 1'b1;
					if (key_tmr >= key_db_ms) begin
						key_db = 1'b0;
						key_st = 1'b1;
					end
				end
			end
		end
		r.plug_type    = cur_type;
		r.type_changed = cur_type != old_type;
		r.micbias_on   = bias;
		r.key_pressed  = key_st;
		r.key_changed  = key_st != old_key;
		r.detecting    = ph != PH_IDLE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		jack_report_t want;
		jack_report_t seen;
		if (!arst_n) begin
			det_db_ms = DETECT_DB_RST;
			settle_len = SETTLE_RST;
			key_db_ms = KEY_DB_RST;
			zones_used = ZONES_RST;
			for (int i = 0; i < ZONE_REGS; i++) begin
				zone_word[i] = '0;
				zone_hits[i] = '0;
			end
			ph = PH_IDLE;
			ph_tmr = '0;
			cur_type = TYPE_NONE;
			key_st = 1'b0;
			key_en = 1'b0;
			key_db = 1'b0;
			key_tmr = '0;
			bias = 1'b0;
			prev_det = 1'b0;
			prev_send = 1'b0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_DETECT_DB: det_db_ms = pwdata[MS_W-1:0];
					REG_SETTLE:    settle_len = pwdata[MS_W-1:0];
					REG_KEY_DB:    key_db_ms = pwdata[MS_W-1:0];
					REG_ZONES:     zones_used = pwdata[2:0];
					REG_ZONE0:     zone_word[0] = pwdata[ZW_W-1:0];
					REG_ZONE1:     zone_word[1] = pwdata[ZW_W-1:0];
					REG_ZONE2:     zone_word[2] = pwdata[ZW_W-1:0];
					REG_ZONE3:     zone_word[3] = pwdata[ZW_W-1:0];
					default: ;
				endcase
			end
			// results leave before this edge's request is predicted
			if (out_valid && !out_stall) begin
				seen = '{plug_type, type_changed, micbias_on, key_pressed, key_changed,
					detecting};
				if (expected_reports.size() == 0) begin
					$error("result with nothing expected: plug_type %0d", plug_type);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (seen.plug_type !== want.plug_type) begin
						$error("plug_type expected %0d got %0d", want.plug_type, seen.plug_type);
						fail_count++;
					end
					if (seen.type_changed !== want.type_changed) begin
						$error("type_changed expected %0d got %0d", want.type_changed,
							seen.type_changed);
						fail_count++;
					end
					if (seen.micbias_on !== want.micbias_on) begin
						$error("micbias_on expected %0d got %0d", want.micbias_on, seen.micbias_on);
						fail_count++;
					end
					if (seen.key_pressed !== want.key_pressed) begin
						$error("key_pressed expected %0d got %0d", want.key_pressed,
							seen.key_pressed);
						fail_count++;
					end
					if (seen.key_changed !== want.key_changed) begin
						$error("key_changed expected %0d got %0d", want.key_changed,
							seen.key_changed);
						fail_count++;
					end
					if (seen.detecting !== want.detecting) begin
						$error("detecting expected %0d got %0d", want.detecting, seen.detecting);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_tick(want);
				expected_reports.push_back(want);
			end
			pending = expected_reports.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import hjtd_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic              det_level;
	logic              send_level;
	logic [ADC_W-1:0]  adc_sample;
	logic              in_call;
	logic [TYPE_W-1:0] forced_type;
	logic              out_valid;
	logic              out_stall;
	logic [TYPE_W-1:0] plug_type;
	logic              type_changed;
	logic              micbias_on;
	logic              key_pressed;
	logic              key_changed;
	logic              detecting;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [5:0]        paddr;
	logic [63:0]       pwdata;
	logic [63:0]       prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	logic [ZW_W-1:0]   reg_val [8];
	int                burst_left;
	int                sent_reqs;
	bit                hold_req;
	bit                noise_det;

	headset_jack_type_detector #(.MAX_ZONES(4)) u_top (.*);

	jack_report_checker u_check (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [ZW_W-1:0] pack_zone(input int high, input int chk, input int dly,
		input int typ);
		return {typ[2:0], dly[15:0], chk[7:0], high[11:0]};
	endfunction

	// sender: bursts of requests with random gaps in between
	task automatic send_req(input logic m, input logic d, input logic s,
		input logic [ADC_W-1:0] a, input logic c, input logic [TYPE_W-1:0] f);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		det_level <= d;
		send_level <= s;
		adc_sample <= a;
		in_call <= c;
		forced_type <= f;
		do @(posedge clk); while (in_stall);
		sent_reqs++;
	endtask

	task automatic tick(input logic d, input logic s, input logic [ADC_W-1:0] a, input logic c);
		send_req(MODE_TICK, d, s, a, c, TYPE_W'($urandom));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs();
		int i;
		for (i = 0; i < 8; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= 6'(i * 8);
			pwdata <= 64'(reg_val[i]);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic noise_reqs(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 3) == 0)
				noise_det = !noise_det;
			send_req(($urandom_range(0, 9) == 0) ? MODE_FORCE : MODE_TICK, noise_det,
				1'($urandom), ADC_W'($urandom), 1'($urandom), TYPE_W'($urandom));
		end
	endtask

	// plug in, hold through debounce, settle and some classification, then unplug
	task automatic plug_session();
		int len, i, z, send_hold;
		logic send_lv, call;
		logic [ADC_W-1:0] a;
		len = int'(reg_val[REG_DETECT_DB]) + int'(reg_val[REG_SETTLE]) + $urandom_range(2, 30);
		call = ($urandom_range(0, 3) == 0);
		send_lv = 1'b0;
		send_hold = $urandom_range(1, 4);
		a = ADC_W'($urandom);
		repeat ($urandom_range(1, 3)) tick(1'b0, 1'b0, ADC_W'($urandom), call);
		for (i = 0; i < len; i++) begin
			if (send_hold == 0) begin
				send_lv = !send_lv;
				send_hold = $urandom_range(1, int'(reg_val[REG_KEY_DB]) + 4);
			end
			send_hold--;
			z = $urandom_range(0, ZONE_REGS - 1);
			// mostly aim at or below a zone bound
			if ($urandom_range(0, 9) < 6)
				a = ADC_W'($urandom_range(0, int'(reg_val[REG_ZONE0 + z][ADC_W-1:0])));
			else
				a = ADC_W'($urandom);
			if ($urandom_range(0, 40) == 0)
				send_req(MODE_FORCE, 1'($urandom), 1'($urandom), a, 1'($urandom),
					($urandom_range(0, 1) == 0) ? TYPE_FOUR_POLE : 3'($urandom));
			else
				tick(($urandom_range(0, 60) != 0), send_lv, a, call);
		end
		tick(1'b0, send_lv, a, call);
	endtask

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin : receiver
		int stretch, style;
		stretch = 0;
		style = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
			end
			if (stretch == 0) begin
				style = $urandom_range(0, 3);
				stretch = $urandom_range(10, 150);
			end
			stretch--;
			case (style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	initial begin : stimulus
		int p, i, start, quota;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_TICK;
		det_level <= 1'b0;
		send_level <= 1'b0;
		adc_sample <= '0;
		in_call <= 1'b0;
		forced_type <= TYPE_NONE;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		burst_left = 0;
		sent_reqs = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_val[REG_DETECT_DB] = ZW_W'(2);
		reg_val[REG_SETTLE] = ZW_W'(0);
		reg_val[REG_KEY_DB] = ZW_W'(2);
		reg_val[REG_ZONES] = ZW_W'(2);
		reg_val[REG_ZONE0] = pack_zone(1000, 0, 0, int'(TYPE_FOUR_POLE));
		reg_val[REG_ZONE1] = pack_zone(3000, 1, 3, 3);
		reg_val[REG_ZONE2] = pack_zone(4095, 255, 1, 6);
		reg_val[REG_ZONE3] = pack_zone(4095, 0, 0, 7);
		program_regs();

		// plug-in, no zone match, four-pole, key press and release
		tick(1'b1, 1'b0, 12'd0, 1'b0);
		tick(1'b1, 1'b0, 12'd4095, 1'b0);
		tick(1'b1, 1'b0, 12'd4095, 1'b0);
		tick(1'b1, 1'b0, 12'd0, 1'b0);
		tick(1'b1, 1'b1, 12'd0, 1'b0);
		tick(1'b1, 1'b1, 12'd0, 1'b0);
		tick(1'b1, 1'b0, 12'd0, 1'b0);
		tick(1'b1, 1'b1, 12'd0, 1'b0);
		// unplug during key debounce while in a call
		tick(1'b0, 1'b1, 12'd0, 1'b1);
		// forced writes: four-pole, same again, other type, none
		send_req(MODE_FORCE, 1'b0, 1'b0, 12'd0, 1'b0, TYPE_FOUR_POLE);
		send_req(MODE_FORCE, 1'b0, 1'b0, 12'd0, 1'b0, TYPE_FOUR_POLE);
		send_req(MODE_FORCE, 1'b0, 1'b0, 12'd0, 1'b0, 3'd5);
		send_req(MODE_FORCE, 1'b0, 1'b0, 12'd0, 1'b0, TYPE_NONE);
		// zone with a check count and a delay
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b1, 1'b1, 12'd2000, 1'b0);
		tick(1'b0, 1'b0, 12'd4095, 1'b1);
		// detect lost during debounce
		tick(1'b1, 1'b1, 12'd4095, 1'b0);
		tick(1'b0, 1'b0, 12'd0, 1'b0);
		send_req(MODE_FORCE, 1'b1, 1'b1, 12'd4095, 1'b1, 3'd7);
		send_req(MODE_FORCE, 1'b0, 1'b0, 12'd0, 1'b0, TYPE_NONE);
		quiesce();

		for (p = 0; p < 8; p++) begin
			if (p == 2) begin
				reg_val[REG_DETECT_DB] = ZW_W'(1023);
				reg_val[REG_SETTLE] = ZW_W'(1023);
				reg_val[REG_KEY_DB] = ZW_W'(1023);
				reg_val[REG_ZONES] = ZW_W'(7);
				for (i = 0; i < ZONE_REGS; i++)
					reg_val[REG_ZONE0 + i] = '1;
			end else if (p == 5) begin
				reg_val[REG_DETECT_DB] = ZW_W'(0);
				reg_val[REG_SETTLE] = ZW_W'(0);
				reg_val[REG_KEY_DB] = ZW_W'(0);
				reg_val[REG_ZONES] = ZW_W'(0);
			end else begin
				reg_val[REG_DETECT_DB] = ZW_W'(($urandom_range(0, 5) == 0) ?
					$urandom_range(0, 1) : $urandom_range(1, 8));
				reg_val[REG_SETTLE] = ZW_W'(($urandom_range(0, 2) == 0) ? 0
					: $urandom_range(1, 8));
				reg_val[REG_KEY_DB] = ZW_W'(($urandom_range(0, 7) == 0) ? 0
					: $urandom_range(1, 6));
				reg_val[REG_ZONES] = ZW_W'(($urandom_range(0, 4) == 0) ?
					$urandom_range(0, 7) : $urandom_range(1, 4));
				for (i = 0; i < ZONE_REGS; i++)
					reg_val[REG_ZONE0 + i] = pack_zone(
						(i + 1) * 1024 - 1 - $urandom_range(0, 700),
						($urandom_range(0, 11) == 0) ? 255 : $urandom_range(0, 3),
						($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
							: $urandom_range(0, 3),
						($urandom_range(0, 4) < 2) ? int'(TYPE_FOUR_POLE)
							: $urandom_range(0, 7));
			end
			program_regs();
			if (p == 3)
				hold_req = 1'b1;
			start = sent_reqs;
			quota = (p == 5) ? 60 : 90;
			if (p == 2) begin
				noise_reqs(120);
			end else begin
				while (sent_reqs - start < quota) begin
					if ($urandom_range(0, 4) == 0)
						noise_reqs(5);
					else
						plug_session();
				end
			end
			quiesce();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
